/* sv/tapsc_pkg.sv */
// Shared types, widths, register codes and reset values for the two-axis
// PD servo controller. No dependencies; every other file imports this package.

package tapsc_pkg;

    // Field widths
    localparam int TILT_W  = 13;
    localparam int OFF_W   = 10;
    localparam int TIME_W  = 32;
    localparam int GAIN_W  = 16;
    localparam int SLOPE_W = 16;
    localparam int ICPT_W  = 8;
    localparam int SERVO_W = 8;
    localparam int RATE_W  = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Fixed-point scaling
    localparam int GAIN_FRAC_BITS       = 12;
    localparam int SERVO_SHIFT          = GAIN_FRAC_BITS + 12;
    localparam int TICKS_PER_SECOND_DEF = 1000000;

    // Shared multiplier and accumulator widths
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 33;
    localparam int MUL_W   = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = 50;
    localparam int SPLIT_W = 25;
    localparam int ACC_W   = MUL_W + SPLIT_W;

    // Largest magnitude of an angle difference
    localparam longint unsigned DIFF_MAX_MAG = 64'd8191;

    localparam int SERVO_MAX = 180;

    // Derivative saturation values
    localparam logic signed [RATE_W-1:0] RATE_POS_SAT = 32'sh7FFF_FFFF;
    localparam logic signed [RATE_W-1:0] RATE_NEG_SAT = 32'sh8000_0000;

    // Register reset values
    localparam logic [GAIN_W-1:0]         PROP_GAIN_RST   = 16'd1229;
    localparam logic [GAIN_W-1:0]         DERIV_GAIN_RST  = 16'd410;
    localparam logic signed [OFF_W-1:0]   OFFSET_X_RST    = 10'sd12;
    localparam logic signed [OFF_W-1:0]   OFFSET_Y_RST    = 10'sd16;
    localparam logic signed [SLOPE_W-1:0] SLOPE_X_RST     = 16'sd1249;
    localparam logic [ICPT_W-1:0]         INTERCEPT_X_RST = 8'd72;
    localparam logic signed [SLOPE_W-1:0] SLOPE_Y_RST     = -16'sd1014;
    localparam logic [ICPT_W-1:0]         INTERCEPT_Y_RST = 8'd52;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN   = 4'd0,
        REG_DERIV_GAIN  = 4'd1,
        REG_OFFSET_X    = 4'd2,
        REG_OFFSET_Y    = 4'd3,
        REG_SLOPE_X     = 4'd4,
        REG_INTERCEPT_X = 4'd5,
        REG_SLOPE_Y     = 4'd6,
        REG_INTERCEPT_Y = 4'd7
    } reg_idx_t;

    // Datapath operations, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ANGLE,   // offset, saturate, compare, time delta
        OP_TMUL,    // difference times tick rate
        OP_DLOAD,   // load divider
        OP_DSTEP,   // two quotient bits
        OP_DDONE,   // saturate rate, update kept angle and time
        OP_PMUL,    // angle times prop gain
        OP_RMUL,    // rate times deriv gain
        OP_SUM,     // PD sum
        OP_SLO,     // slope times low half of sum
        OP_SHI,     // slope times high half of sum
        OP_ACC,     // combine halves
        OP_SERVO,   // scale, offset, clip
        OP_OUT      // load output register
    } op_t;

    typedef struct packed {
        op_t  op;
        logic axis;
    } dp_cmd_t;

    typedef struct packed {
        logic changed;
        logic out_free;
    } dp_stat_t;

    typedef struct packed {
        logic                  wr;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // Dividend width for a given tick rate, rounded up to even (two bits a step)
    function automatic int div_num_bits(input longint unsigned tps);
        int n;
        n = $clog2(DIFF_MAX_MAG * tps + 64'd1);
        return n + (n % 2);
    endfunction

endpackage

/* sv/tapsc_ctrl.sv */
// Sequencer for the two-axis PD servo controller: walks each axis through
// the datapath operations. Depends on tapsc_pkg.

module tapsc_ctrl
    import tapsc_pkg::*;
#(
    parameter int DIV_STEPS = div_num_bits(TICKS_PER_SECOND_DEF) / 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_TMUL,
        ST_DLOAD,
        ST_DSTEP,
        ST_DDONE,
        ST_PMUL,
        ST_RMUL,
        ST_SUM,
        ST_SLO,
        ST_SHI,
        ST_ACC,
        ST_SERVO,
        ST_OUTW,
        ST_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic               axis_reg, axis_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    dp_cmd_t            cmd_reg, cmd_next;
    logic               stall_reg, stall_next;

    function automatic op_t op_of(input state_t s);
        op_t o;
        unique case (s)
            ST_ANGLE: o = OP_ANGLE;
            ST_TMUL:  o = OP_TMUL;
            ST_DLOAD: o = OP_DLOAD;
            ST_DSTEP: o = OP_DSTEP;
            ST_DDONE: o = OP_DDONE;
            ST_PMUL:  o = OP_PMUL;
            ST_RMUL:  o = OP_RMUL;
            ST_SUM:   o = OP_SUM;
            ST_SLO:   o = OP_SLO;
            ST_SHI:   o = OP_SHI;
            ST_ACC:   o = OP_ACC;
            ST_SERVO: o = OP_SERVO;
            ST_OUT:   o = OP_OUT;
            default:  o = OP_NONE;
        endcase
        return o;
    endfunction

    // Next state
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ANGLE;
                    axis_next  = 1'b0;
                end
            end
            ST_ANGLE: state_next = ST_TMUL;
            ST_TMUL:  state_next = stat.changed ? ST_DLOAD : ST_PMUL;
            ST_DLOAD:
            begin
                state_next = ST_DSTEP;
                cnt_next   = CNT_W'(DIV_STEPS - 1);
            end
            ST_DSTEP:
            begin
                if (cnt_reg == '0)
                    state_next = ST_DDONE;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_DDONE: state_next = ST_PMUL;
            ST_PMUL:  state_next = ST_RMUL;
            ST_RMUL:  state_next = ST_SUM;
            ST_SUM:   state_next = ST_SLO;
            ST_SLO:   state_next = ST_SHI;
            ST_SHI:   state_next = ST_ACC;
            ST_ACC:   state_next = ST_SERVO;
            ST_SERVO:
            begin
                if (axis_reg)
                    state_next = ST_OUTW;
                else
                begin
                    state_next = ST_ANGLE;
                    axis_next  = 1'b1;
                end
            end
            ST_OUTW:  state_next = stat.out_free ? ST_OUT : ST_OUTW;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
        cmd_next.op   = op_of(state_next);
        cmd_next.axis = axis_next;
        stall_next    = (state_next != ST_IDLE);
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= 1'b0;
            cnt_reg   <= '0;
            cmd_reg   <= '{op: OP_NONE, axis: 1'b0};
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            cnt_reg   <= cnt_next;
            cmd_reg   <= cmd_next;
            stall_reg <= stall_next;
        end
    end

    assign cmd      = cmd_reg;
    assign in_stall = stall_reg;

endmodule

/* sv/tapsc_dp.sv */
// Datapath of the two-axis PD servo controller: configuration registers,
// per-axis state, shared multiplier, radix-4 divider and output register.
// Depends on tapsc_pkg.

module tapsc_dp
    import tapsc_pkg::*;
#(
    parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dp_cmd_t                   cmd,
    output dp_stat_t                  stat,
    input  cfg_wr_t                   cfg,
    input  logic                      in_take,
    input  logic signed [TILT_W-1:0]  tilt_x,
    input  logic signed [TILT_W-1:0]  tilt_y,
    input  logic [TIME_W-1:0]         time_us,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [SERVO_W-1:0]        servo_x,
    output logic [SERVO_W-1:0]        servo_y,
    output logic signed [TILT_W-1:0]  angle_x,
    output logic signed [TILT_W-1:0]  angle_y
);

    localparam int NUM_E = div_num_bits(longint'(TICKS_PER_SECOND));
    localparam int QX_W  = (NUM_E > RATE_W + 1) ? NUM_E : RATE_W + 1;
    localparam int SH_W  = ACC_W - SERVO_SHIFT;
    localparam int DIFF_W = TILT_W + 1;
    localparam logic signed [MUL_B_W-1:0] TPS_B = MUL_B_W'(TICKS_PER_SECOND);
    localparam logic signed [TILT_W-1:0] ANG_MAX = TILT_W'(2 ** (TILT_W - 1) - 1);
    localparam logic signed [TILT_W-1:0] ANG_MIN = TILT_W'(-(2 ** (TILT_W - 1)));
    localparam logic [ACC_W-1:0] RND = ACC_W'((64'd1 << SERVO_SHIFT) - 64'd1);
    localparam logic [QX_W-1:0] Q_POS_LIM = QX_W'(64'h7FFF_FFFF);
    localparam logic [QX_W-1:0] Q_NEG_LIM = QX_W'(64'h8000_0000);

    // Configuration registers
    logic [GAIN_W-1:0]         prop_gain_reg, deriv_gain_reg;
    logic signed [OFF_W-1:0]   offset_x_reg, offset_y_reg;
    logic signed [SLOPE_W-1:0] slope_x_reg, slope_y_reg;
    logic [ICPT_W-1:0]         intercept_x_reg, intercept_y_reg;

    // Per-axis state
    logic signed [TILT_W-1:0]  kept_ang_reg [2];
    logic [TIME_W-1:0]         kept_time_reg [2];
    logic signed [RATE_W-1:0]  rate_reg [2];

    // Captured item and per-axis results
    logic signed [TILT_W-1:0]  tilt_x_reg, tilt_y_reg;
    logic [TIME_W-1:0]         time_reg;
    logic signed [TILT_W-1:0]  ang_reg [2];
    logic [SERVO_W-1:0]        servo_reg [2];

    // Working registers
    logic                      changed_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic [TIME_W-1:0]         dt_reg;
    logic signed [MUL_W-1:0]   mul_reg;
    logic                      neg_reg;
    logic [NUM_E-1:0]          num_reg;
    logic [NUM_E-1:0]          quo_reg;
    logic [TIME_W-1:0]         rem_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [ACC_W-1:0]   acc_reg;

    // Output register
    logic                      out_valid_reg;
    logic [SERVO_W-1:0]        servo_x_reg, servo_y_reg;
    logic signed [TILT_W-1:0]  angle_x_reg, angle_y_reg;

    logic                      ax;
    assign ax = cmd.axis;

    // Angle correction and change detect
    logic signed [TILT_W-1:0]  tilt_sel;
    logic signed [OFF_W-1:0]   off_sel;
    logic signed [TILT_W:0]    raw_sum;
    logic signed [TILT_W-1:0]  ang_sat;
    logic [TIME_W-1:0]         dt_raw, dt_val;

    always_comb
    begin
        tilt_sel = ax ? tilt_y_reg : tilt_x_reg;
        off_sel  = ax ? offset_y_reg : offset_x_reg;
        raw_sum  = (TILT_W + 1)'(tilt_sel) + (TILT_W + 1)'(off_sel);
        if (raw_sum > (TILT_W + 1)'(ANG_MAX))
            ang_sat = ANG_MAX;
        else if (raw_sum < (TILT_W + 1)'(ANG_MIN))
            ang_sat = ANG_MIN;
        else
            ang_sat = raw_sum[TILT_W-1:0];
        dt_raw = time_reg - kept_time_reg[ax];
        dt_val = (dt_raw == '0) ? TIME_W'(1) : dt_raw;
    end

    // Shared multiplier, registered every cycle
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_A_W-1:0] slope_eff;
    logic signed [MUL_W-1:0]   mul_p;

    always_comb
    begin
        slope_eff = ax ? -MUL_A_W'(slope_y_reg) : MUL_A_W'(slope_x_reg);
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_TMUL:
            begin
                mul_a = MUL_A_W'(diff_reg);
                mul_b = TPS_B;
            end
            OP_PMUL:
            begin
                mul_a = $signed({1'b0, prop_gain_reg});
                mul_b = MUL_B_W'(ang_reg[ax]);
            end
            OP_RMUL:
            begin
                mul_a = $signed({1'b0, deriv_gain_reg});
                mul_b = MUL_B_W'(rate_reg[ax]);
            end
            OP_SLO:
            begin
                mul_a = slope_eff;
                mul_b = $signed({{(MUL_B_W - SPLIT_W){1'b0}}, sum_reg[SPLIT_W-1:0]});
            end
            OP_SHI:
            begin
                mul_a = slope_eff;
                mul_b = MUL_B_W'($signed(sum_reg[SUM_W-1:SPLIT_W]));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);
    end

    // Divider: two restoring steps per cycle
    logic signed [MUL_W-1:0]   mul_abs;
    logic [TIME_W:0]           r1, r2;
    logic                      ge1, ge2;
    logic [TIME_W-1:0]         rem1, rem2;

    always_comb
    begin
        mul_abs = mul_reg[MUL_W-1] ? -mul_reg : mul_reg;
        r1   = {rem_reg, num_reg[NUM_E-1]};
        ge1  = (r1 >= {1'b0, dt_reg});
        rem1 = ge1 ? TIME_W'(r1 - {1'b0, dt_reg}) : r1[TIME_W-1:0];
        r2   = {rem1, num_reg[NUM_E-2]};
        ge2  = (r2 >= {1'b0, dt_reg});
        rem2 = ge2 ? TIME_W'(r2 - {1'b0, dt_reg}) : r2[TIME_W-1:0];
    end

    // Rate saturation
    logic [QX_W-1:0]           quo_x;
    logic signed [RATE_W-1:0]  rate_new;

    always_comb
    begin
        quo_x = QX_W'(quo_reg);
        if (!neg_reg)
            rate_new = (quo_x > Q_POS_LIM) ? RATE_POS_SAT : $signed(quo_x[RATE_W-1:0]);
        else
            rate_new = (quo_x > Q_NEG_LIM) ? RATE_NEG_SAT : -$signed(quo_x[RATE_W-1:0]);
    end

    // Servo scaling: truncate toward zero, add intercept, clip
    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [SH_W-1:0]    acc_sh;
    logic signed [SH_W-1:0]    servo_v;
    logic [ICPT_W-1:0]         icpt_sel;
    logic [SERVO_W-1:0]        servo_new;

    always_comb
    begin
        icpt_sel = ax ? intercept_y_reg : intercept_x_reg;
        acc_rnd  = acc_reg + (acc_reg[ACC_W-1] ? $signed(RND) : $signed(ACC_W'(0)));
        acc_sh   = SH_W'(acc_rnd >>> SERVO_SHIFT);
        servo_v  = acc_sh + $signed({{(SH_W - ICPT_W){1'b0}}, icpt_sel});
        if (servo_v < 0)
            servo_new = '0;
        else if (servo_v > SH_W'(SERVO_MAX))
            servo_new = SERVO_W'(SERVO_MAX);
        else
            servo_new = servo_v[SERVO_W-1:0];
    end

    // Config, axis state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg    <= PROP_GAIN_RST;
            deriv_gain_reg   <= DERIV_GAIN_RST;
            offset_x_reg     <= OFFSET_X_RST;
            offset_y_reg     <= OFFSET_Y_RST;
            slope_x_reg      <= SLOPE_X_RST;
            intercept_x_reg  <= INTERCEPT_X_RST;
            slope_y_reg      <= SLOPE_Y_RST;
            intercept_y_reg  <= INTERCEPT_Y_RST;
            kept_ang_reg[0]  <= '0;
            kept_ang_reg[1]  <= '0;
            kept_time_reg[0] <= '0;
            kept_time_reg[1] <= '0;
            rate_reg[0]      <= '0;
            rate_reg[1]      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.wr)
            begin
                unique case (reg_idx_t'(cfg.idx))
                    REG_PROP_GAIN:   prop_gain_reg   <= cfg.data[GAIN_W-1:0];
                    REG_DERIV_GAIN:  deriv_gain_reg  <= cfg.data[GAIN_W-1:0];
                    REG_OFFSET_X:    offset_x_reg    <= $signed(cfg.data[OFF_W-1:0]);
                    REG_OFFSET_Y:    offset_y_reg    <= $signed(cfg.data[OFF_W-1:0]);
                    REG_SLOPE_X:     slope_x_reg     <= $signed(cfg.data[SLOPE_W-1:0]);
                    REG_INTERCEPT_X: intercept_x_reg <= cfg.data[ICPT_W-1:0];
                    REG_SLOPE_Y:     slope_y_reg     <= $signed(cfg.data[SLOPE_W-1:0]);
                    REG_INTERCEPT_Y: intercept_y_reg <= cfg.data[ICPT_W-1:0];
                    default:         ;
                endcase
            end
            if (cmd.op == OP_DDONE)
            begin
                rate_reg[ax]      <= rate_new;
                kept_ang_reg[ax]  <= ang_reg[ax];
                kept_time_reg[ax] <= time_reg;
            end
            if (cmd.op == OP_OUT)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_p;
        if (in_take)
        begin
            tilt_x_reg <= tilt_x;
            tilt_y_reg <= tilt_y;
            time_reg   <= time_us;
        end
        case (cmd.op)
            OP_ANGLE:
            begin
                ang_reg[ax] <= ang_sat;
                changed_reg <= (ang_sat != kept_ang_reg[ax]);
                diff_reg    <= DIFF_W'(ang_sat) - DIFF_W'(kept_ang_reg[ax]);
                dt_reg      <= dt_val;
            end
            OP_DLOAD:
            begin
                neg_reg <= mul_reg[MUL_W-1];
                num_reg <= mul_abs[NUM_E-1:0];
                quo_reg <= '0;
                rem_reg <= '0;
            end
            OP_DSTEP:
            begin
                num_reg <= {num_reg[NUM_E-3:0], 2'b00};
                quo_reg <= {quo_reg[NUM_E-3:0], ge1, ge2};
                rem_reg <= rem2;
            end
            OP_RMUL:  sum_reg <= SUM_W'(mul_reg);
            OP_SUM:   sum_reg <= sum_reg + SUM_W'(mul_reg);
            OP_SHI:   acc_reg <= ACC_W'(mul_reg);
            OP_ACC:   acc_reg <= acc_reg + (ACC_W'(mul_reg) <<< SPLIT_W);
            OP_SERVO: servo_reg[ax] <= servo_new;
            OP_OUT:
            begin
                servo_x_reg <= servo_reg[0];
                servo_y_reg <= servo_reg[1];
                angle_x_reg <= ang_reg[0];
                angle_y_reg <= ang_reg[1];
            end
            default: ;
        endcase
    end

    assign stat.changed  = changed_reg;
    assign stat.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign servo_x   = servo_x_reg;
    assign servo_y   = servo_y_reg;
    assign angle_x   = angle_x_reg;
    assign angle_y   = angle_y_reg;

endmodule

/* sv/two_axis_pd_servo_control.sv */
// A sample beat is taken only while idle: in_stall stays high from the accepted beat
//   until the results of both axes are loaded into the output register.
// The 2-bit-per-cycle divider dominates the work when an angle changes.
// A finished result waits in the output register while the next beat is taken.
// Reset (rst_n, async, active low) loads register defaults and clears the kept
//   angles, times and rates; no clearing pass.

module two_axis_pd_servo_control
    import tapsc_pkg::*;
#(
    parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [TILT_W-1:0]  tilt_x,
    input  logic signed [TILT_W-1:0]  tilt_y,
    input  logic [TIME_W-1:0]         time_us,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [SERVO_W-1:0]        servo_x,
    output logic [SERVO_W-1:0]        servo_y,
    output logic signed [TILT_W-1:0]  angle_x,
    output logic signed [TILT_W-1:0]  angle_y,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    localparam int DIV_STEPS = div_num_bits(longint'(TICKS_PER_SECOND)) / 2;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    cfg_wr_t  cfg;
    logic     in_take;

    // Config writes are always accepted and never stalled
    assign cfg_ready = 1'b1;
    assign cfg.wr    = cfg_valid && cfg_ready;
    assign cfg.idx   = cfg_index;
    assign cfg.data  = cfg_data;

    assign in_take = in_valid && !in_stall;

    tapsc_ctrl #(
        .DIV_STEPS (DIV_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    tapsc_dp #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg       (cfg),
        .in_take   (in_take),
        .tilt_x    (tilt_x),
        .tilt_y    (tilt_y),
        .time_us   (time_us),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .servo_x   (servo_x),
        .servo_y   (servo_y),
        .angle_x   (angle_x),
        .angle_y   (angle_y)
    );

endmodule

/* sv/tapsc_checker.sv */
// Port-level checks for the two-axis PD servo controller, bound to the top level.
// Depends on tapsc_pkg and two_axis_pd_servo_control.

module tapsc_checker
    import tapsc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic [SERVO_W-1:0]        servo_x,
    input  logic [SERVO_W-1:0]        servo_y,
    input  logic signed [TILT_W-1:0]  angle_x,
    input  logic signed [TILT_W-1:0]  angle_y
);

    // An accepted beat makes the block busy
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accepted beat");

    // Servo commands stay in range
    a_servo_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (servo_x <= 8'd180 && servo_y <= 8'd180))
        else $error("servo command out of range");

    // A new result frees the input side
    a_ready_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("input still stalled when result posted");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(servo_x) && $stable(servo_y)
            && $stable(angle_x) && $stable(angle_y)))
        else $error("stalled result changed");

endmodule

bind two_axis_pd_servo_control tapsc_checker u_tapsc_checker (.*);

/* sim/pd_servo_checker.sv */
// Checker for the two-axis PD servo controller: follows register writes, predicts
// the servo commands and corrected angles of every accepted sample beat, and compares.
// Depends on tapsc_pkg.

module pd_servo_checker
    import tapsc_pkg::*;
#(
    parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic signed [TILT_W-1:0] tilt_x,
    input  logic signed [TILT_W-1:0] tilt_y,
    input  logic [TIME_W-1:0]        time_us,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic [SERVO_W-1:0]       servo_x,
    input  logic [SERVO_W-1:0]       servo_y,
    input  logic signed [TILT_W-1:0] angle_x,
    input  logic signed [TILT_W-1:0] angle_y,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    output int                       outstanding,
    output int                       mismatches
);

    localparam int     AXIS_X    = 0;
    localparam int     AXIS_Y    = 1;
    localparam longint SERVO_DIV = longint'(1) << SERVO_SHIFT;
    localparam longint ANGLE_MAX = (longint'(1) << (TILT_W - 1)) - 1;
    localparam longint ANGLE_MIN = -(longint'(1) << (TILT_W - 1));
    localparam longint RATE_MAX  = (longint'(1) << (RATE_W - 1)) - 1;
    localparam longint RATE_MIN  = -(longint'(1) << (RATE_W - 1));

    typedef struct packed {
        logic [SERVO_W-1:0]        servo_x;
        logic [SERVO_W-1:0]        servo_y;
        logic signed [TILT_W-1:0]  angle_x;
        logic signed [TILT_W-1:0]  angle_y;
    } servo_cmd_t;

    // Shadow registers
    logic [GAIN_W-1:0]         prop_gain;
    logic [GAIN_W-1:0]         deriv_gain;
    logic signed [OFF_W-1:0]   offset    [2];
    logic signed [SLOPE_W-1:0] slope     [2];
    logic [ICPT_W-1:0]         intercept [2];

    // Per-axis history: last kept angle, its timestamp and the held derivative
    longint            kept_angle [2];
    logic [TIME_W-1:0] kept_time  [2];
    longint            rate       [2];

    servo_cmd_t cmd_q [$];

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // One axis: correct the angle, refresh the derivative on a change, map PD to servo
    function automatic logic [SERVO_W-1:0] axis_update(
        input  int                       ax,
        input  logic signed [TILT_W-1:0] tilt,
        input  logic [TIME_W-1:0]        stamp,
        output logic signed [TILT_W-1:0] angle_out
    );
        longint            angle;
        longint            span;
        longint            sum;
        longint            servo;
        logic [TIME_W-1:0] dt;
        angle = clamp(longint'(tilt) + longint'(offset[ax]), ANGLE_MIN, ANGLE_MAX);
        if (angle != kept_angle[ax]) begin
            dt = stamp - kept_time[ax];
            if (dt == '0)
                dt = 1;
            span = dt;
            rate[ax] = clamp((angle - kept_angle[ax]) * TICKS_PER_SECOND / span,
                             RATE_MIN, RATE_MAX);
            kept_angle[ax] = angle;
            kept_time[ax]  = stamp;
        end
        sum = angle * longint'(prop_gain) + rate[ax] * longint'(deriv_gain);
        // Y servo is driven by the negated PD term
        if (ax == AXIS_Y)
            sum = -sum;
        servo = longint'(slope[ax]) * sum / SERVO_DIV + longint'(intercept[ax]);
        servo = clamp(servo, 0, SERVO_MAX);
        angle_out = angle[TILT_W-1:0];
        return servo[SERVO_W-1:0];
    endfunction

    function automatic void check_field(
        input string              field,
        input logic signed [31:0] want,
        input logic signed [31:0] got
    );
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        servo_cmd_t               want;
        logic signed [TILT_W-1:0] ang_x;
        logic signed [TILT_W-1:0] ang_y;
        if (!rst_n) begin
            prop_gain      = PROP_GAIN_RST;
            deriv_gain     = DERIV_GAIN_RST;
            offset[AXIS_X] = OFFSET_X_RST;
            offset[AXIS_Y] = OFFSET_Y_RST;
            slope[AXIS_X]  = SLOPE_X_RST;
            slope[AXIS_Y]  = SLOPE_Y_RST;
            intercept[AXIS_X] = INTERCEPT_X_RST;
            intercept[AXIS_Y] = INTERCEPT_Y_RST;
            for (int a = 0; a < 2; a++) begin
                kept_angle[a] = 0;
                kept_time[a]  = '0;
                rate[a]       = 0;
            end
            cmd_q.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else begin
            // Result beat: compare against the oldest prediction
            if (out_valid && !out_stall) begin
                if (cmd_q.size() == 0) begin
                    $display("%0t: result beat expected none, got servo %0d/%0d angle %0d/%0d",
                             $time, servo_x, servo_y, angle_x, angle_y);
                    mismatches++;
                end
                else begin
                    want = cmd_q.pop_front();
                    check_field("servo_x", want.servo_x, servo_x);
                    check_field("servo_y", want.servo_y, servo_y);
                    check_field("angle_x", want.angle_x, angle_x);
                    check_field("angle_y", want.angle_y, angle_y);
                end
            end

            // Register write; spare indexes are ignored
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PROP_GAIN:   prop_gain = cfg_data;
                    REG_DERIV_GAIN:  deriv_gain = cfg_data;
                    REG_OFFSET_X:    offset[AXIS_X] = cfg_data[OFF_W-1:0];
                    REG_OFFSET_Y:    offset[AXIS_Y] = cfg_data[OFF_W-1:0];
                    REG_SLOPE_X:     slope[AXIS_X] = cfg_data;
                    REG_INTERCEPT_X: intercept[AXIS_X] = cfg_data[ICPT_W-1:0];
                    REG_SLOPE_Y:     slope[AXIS_Y] = cfg_data;
                    REG_INTERCEPT_Y: intercept[AXIS_Y] = cfg_data[ICPT_W-1:0];
                    default: ;
                endcase
            end

            // Sample beat: predict its result
            if (in_valid && !in_stall) begin
                want.servo_x = axis_update(AXIS_X, tilt_x, time_us, ang_x);
                want.servo_y = axis_update(AXIS_Y, tilt_y, time_us, ang_y);
                want.angle_x = ang_x;
                want.angle_y = ang_y;
                cmd_q.push_back(want);
            end

            outstanding <= cmd_q.size();
        end
    end

endmodule

/* sim/testbench.sv */
// Top of the servo controller testbench: clock, reset, sample and result traffic,
// register phases and the verdict. Depends on tapsc_pkg, the controller and pd_servo_checker.

module testbench;
    import tapsc_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int RESET_CYCLES  = 11;
    localparam int MAX_GAP       = 13;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 64;

    // Indexes past the register list
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 4'd15;

    localparam logic signed [TILT_W-1:0] TILT_MIN = 13'sh1000;
    localparam logic signed [TILT_W-1:0] TILT_MAX = 13'sh0FFF;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [TILT_W-1:0] tilt_x;
    logic signed [TILT_W-1:0] tilt_y;
    logic [TIME_W-1:0]        time_us;
    logic                     out_valid;
    logic                     out_stall;
    logic [SERVO_W-1:0]       servo_x;
    logic [SERVO_W-1:0]       servo_y;
    logic signed [TILT_W-1:0] angle_x;
    logic signed [TILT_W-1:0] angle_y;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    int outstanding;
    int mismatches;
    int cycle_count = 0;

    // Shared traffic controls
    bit no_idle     = 1'b0;
    bit rx_hold_req = 1'b0;

    // Current pose and timestamp of the random walk
    logic signed [TILT_W-1:0] cur_x;
    logic signed [TILT_W-1:0] cur_y;
    logic [TIME_W-1:0]        now_us;

    two_axis_pd_servo_control u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .tilt_x    (tilt_x),
        .tilt_y    (tilt_y),
        .time_us   (time_us),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .servo_x   (servo_x),
        .servo_y   (servo_y),
        .angle_x   (angle_x),
        .angle_y   (angle_y),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pd_servo_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .tilt_x      (tilt_x),
        .tilt_y      (tilt_y),
        .time_us     (time_us),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .servo_x     (servo_x),
        .servo_y     (servo_y),
        .angle_x     (angle_x),
        .angle_y     (angle_y),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // One sample beat after a random gap; returns at the edge that takes it
    task automatic send_sample(
        input logic signed [TILT_W-1:0] x,
        input logic signed [TILT_W-1:0] y,
        input logic [TIME_W-1:0]        stamp
    );
        int gap;
        gap = no_idle ? 0 : $urandom_range(MAX_GAP, 0);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        tilt_x   <= x;
        tilt_y   <= y;
        time_us  <= stamp;
        do @(posedge clk); while (in_stall);
    endtask

    // Stop offering samples and wait until every result beat is back
    task automatic flush_pipeline();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Leaves cfg_valid high so back-to-back writes need no toggle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Full register set plus one write to a spare index
    task automatic load_settings(
        input logic [CFG_DATA_W-1:0] pg, dg, ox, oy, sx, ix, sy, iy
    );
        logic [CFG_IDX_W-1:0] spare;
        spare = CFG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST));
        write_reg(spare, CFG_DATA_W'($urandom));
        write_reg(REG_PROP_GAIN, pg);
        write_reg(REG_DERIV_GAIN, dg);
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_SLOPE_X, sx);
        write_reg(REG_INTERCEPT_X, ix);
        write_reg(REG_SLOPE_Y, sy);
        write_reg(REG_INTERCEPT_Y, iy);
        cfg_valid <= 1'b0;
    endtask

    // Moderate settings keep the servo mostly off its stops; wild ones use all bits
    task automatic random_settings(input bit wild);
        logic [CFG_DATA_W-1:0] pg, dg, ox, oy, sx, ix, sy, iy;
        if (wild) begin
            pg = CFG_DATA_W'($urandom);
            dg = CFG_DATA_W'($urandom);
            ox = CFG_DATA_W'($urandom);
            oy = CFG_DATA_W'($urandom);
            sx = CFG_DATA_W'($urandom);
            ix = CFG_DATA_W'($urandom);
            sy = CFG_DATA_W'($urandom);
            iy = CFG_DATA_W'($urandom);
        end
        else begin
            pg = CFG_DATA_W'($urandom_range(4095, 0));
            dg = CFG_DATA_W'($urandom_range(1023, 0));
            ox = CFG_DATA_W'(int'($urandom_range(512, 0)) - 256);
            oy = CFG_DATA_W'(int'($urandom_range(512, 0)) - 256);
            sx = CFG_DATA_W'(int'($urandom_range(4096, 0)) - 2048);
            ix = CFG_DATA_W'($urandom_range(SERVO_MAX, 0));
            sy = CFG_DATA_W'(int'($urandom_range(4096, 0)) - 2048);
            iy = CFG_DATA_W'($urandom_range(SERVO_MAX, 0));
        end
        load_settings(pg, dg, ox, oy, sx, ix, sy, iy);
    endtask

    // Mostly a smooth random walk in pose and time, with jumps, holds and repeats
    task automatic run_random(input int count);
        int          kind;
        int          step_x;
        int          step_y;
        logic [31:0] rnd;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(99, 0);
            rnd  = $urandom;
            if (kind < 10) begin
                cur_x = rnd[TILT_W-1:0];
                cur_y = rnd[TILT_W+15:16];
            end
            else if (kind < 25) begin
                // pose unchanged: derivative is held
            end
            else begin
                step_x = int'($urandom_range(64, 0)) - 32;
                step_y = int'($urandom_range(64, 0)) - 32;
                cur_x = cur_x + TILT_W'(step_x);
                if (kind >= 35)
                    cur_y = cur_y + TILT_W'(step_y);
            end
            kind = $urandom_range(99, 0);
            if (kind < 8) begin
                // same timestamp
            end
            else if (kind < 14)
                now_us = $urandom;
            else
                now_us = now_us + TIME_W'($urandom_range(20000, 1));
            send_sample(cur_x, cur_y, now_us);
        end
    endtask

    // Result side: random stall before each beat, one long hold-off on request
    initial
    begin
        int hold;
        out_stall <= 1'b0;
        @(posedge clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold = HOLD_CYCLES;
            end
            else
                hold = no_idle ? 0 : $urandom_range(MAX_GAP, 0);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // Stimulus and verdict
    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        tilt_x    <= '0;
        tilt_y    <= '0;
        time_us   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        cur_x  = '0;
        cur_y  = '0;
        now_us = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: first change with zero time step, holds, saturation, wrap
        send_sample(13'sd0, 13'sd0, 32'h0000_0000);
        send_sample(13'sd0, 13'sd0, 32'h0000_0000);
        send_sample(13'sd0, 13'sd0, 32'h0000_0064);
        send_sample(TILT_MAX, TILT_MIN, 32'h0000_0001);
        send_sample(TILT_MIN, TILT_MAX, 32'h0000_0001);
        send_sample(13'sd100, -13'sd100, 32'hFFFF_FFF0);
        send_sample(13'sd101, -13'sd99, 32'h0000_0010);
        send_sample(13'sd101, -13'sd99, 32'hFFFF_FFFF);
        send_sample(-13'sd12, -13'sd16, 32'h8000_0000);
        send_sample(-13'sd12, -13'sd16, 32'h8000_0000);
        send_sample(13'sd2880, -13'sd2880, 32'h5555_5555);
        send_sample(-13'sd2880, 13'sd2880, 32'hAAAA_AAAA);
        send_sample(13'sh0AAA, 13'sh1555, 32'hAAAA_AAAB);
        send_sample(13'sh1555, 13'sh0AAA, 32'hAAAA_AAAB);
        run_random(40);
        flush_pipeline();

        // Top of every register but offset_y at -512, slope_y at -32768, intercept_y at 0; intercept_x over 180
        load_settings(16'hFFFF, 16'hFFFF, 16'h01FF, 16'h0200,
                      16'h7FFF, 16'h00FF, 16'h8000, 16'h0000);
        send_sample(TILT_MIN, TILT_MIN, 32'h0000_1000);
        send_sample(TILT_MAX, TILT_MAX, 32'h0000_1000);
        send_sample(TILT_MIN, TILT_MAX, 32'h0000_1001);
        run_random(80);
        flush_pipeline();

        // Everything zero
        load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                      16'h0000, 16'h0000, 16'h0000, 16'h0000);
        run_random(60);
        flush_pipeline();

        // Mirror extremes, intercepts at the servo stop
        load_settings(16'h0001, 16'h0001, 16'h0200, 16'h01FF,
                      16'h8000, 16'd180, 16'h7FFF, 16'd180);
        run_random(60);
        flush_pipeline();

        // Random settings, the last phase wild; one phase without idling, one with the long result hold-off
        for (int p = 0; p < 6; p++) begin
            random_settings(p == 5);
            no_idle = (p == 1);
            if (p == 2)
                rx_hold_req = 1'b1;
            run_random(90);
            flush_pipeline();
        end
        no_idle = 1'b0;

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
sv/tapsc_pkg.sv
sv/tapsc_ctrl.sv
sv/tapsc_dp.sv
sv/two_axis_pd_servo_control.sv
sv/tapsc_checker.sv
sim/pd_servo_checker.sv
sim/testbench.sv
